@@ rtl/cvb_pkg.sv @@
// Shared types and constants for the 3x3 valid-mode convolution block.
`default_nettype none
package cvb_pkg;

    localparam int IMAGE_SIDE_DEF = 28;
    localparam int PIX_W          = 8;
    localparam int VALUE_W        = 32;
    localparam int WROW_W         = 24;
    localparam int LINE_W         = 2 * PIX_W;
    localparam int KSIZE          = 3;
    localparam int CFG_IDX_W      = 2;

    localparam logic [VALUE_W-1:0] BIAS_RESET = 32'd1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_WROW0 = 2'd0,
        CFG_WROW1 = 2'd1,
        CFG_WROW2 = 2'd2,
        CFG_BIAS  = 2'd3
    } t_cfg_idx;

    // Control that travels alongside each pipeline beat.
    typedef struct packed {
        logic valid;
        logic last;
    } t_tag;

    typedef logic [KSIZE-1:0][KSIZE-1:0][PIX_W-1:0] t_win;
    typedef logic [KSIZE-1:0][WROW_W-1:0]           t_wrows;

endpackage
`default_nettype wire

@@ rtl/cvb_line_cell.sv @@
// One cell of the line buffer chain: holds the two upper pixels of one column.
`default_nettype none
module cvb_line_cell (
    input  wire logic                      i_clk,
    input  wire logic                      i_en,
    input  wire logic [cvb_pkg::LINE_W-1:0] i_data,
    output logic      [cvb_pkg::LINE_W-1:0] o_data
);
    import cvb_pkg::*;

    logic [LINE_W-1:0] r_data;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_data <= i_data;
        end
    end

    assign o_data = r_data;

endmodule
`default_nettype wire

@@ rtl/cvb_mac.sv @@
// Three-stage multiply-add pipeline: nine products, row sums, bias and total.
`default_nettype none
module cvb_mac (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_en,
    input  wire cvb_pkg::t_tag               i_tag,
    input  wire cvb_pkg::t_win               i_win,
    input  wire cvb_pkg::t_wrows             i_wrow,
    input  wire logic [cvb_pkg::VALUE_W-1:0] i_bias,
    output cvb_pkg::t_tag                    o_tag,
    output logic signed [cvb_pkg::VALUE_W-1:0] o_value
);
    import cvb_pkg::*;

    localparam int PROD_W = 2 * PIX_W;
    localparam int RSUM_W = PROD_W + 2;

    logic [KSIZE-1:0][KSIZE-1:0][PROD_W-1:0] n_prod;
    logic [KSIZE-1:0][KSIZE-1:0][PROD_W-1:0] r_prod;
    logic [KSIZE-1:0][RSUM_W-1:0]            n_rsum;
    logic [KSIZE-1:0][RSUM_W-1:0]            r_rsum;
    logic [VALUE_W-1:0]                      n_value;
    logic [VALUE_W-1:0]                      r_value;
    t_tag                                    r_tag1;
    t_tag                                    r_tag2;
    t_tag                                    r_tag3;

    always_comb begin
        for (int k = 0; k < KSIZE; k++) begin
            for (int l = 0; l < KSIZE; l++) begin
                n_prod[k][l] = PROD_W'(i_win[k][l]) * PROD_W'(i_wrow[k][PIX_W*l +: PIX_W]);
            end
        end
    end

    always_comb begin
        for (int k = 0; k < KSIZE; k++) begin
            n_rsum[k] = RSUM_W'(r_prod[k][0]) + RSUM_W'(r_prod[k][1])
                      + RSUM_W'(r_prod[k][2]);
        end
    end

    // The total wraps modulo 2^32, matching two's-complement overflow.
    assign n_value = i_bias + VALUE_W'(r_rsum[0]) + VALUE_W'(r_rsum[1])
                   + VALUE_W'(r_rsum[2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tag1 <= '0;
            r_tag2 <= '0;
            r_tag3 <= '0;
        end else if (i_en) begin
            r_tag1 <= i_tag;
            r_tag2 <= r_tag1;
            r_tag3 <= r_tag2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod  <= n_prod;
            r_rsum  <= n_rsum;
            r_value <= n_value;
        end
    end

    assign o_tag   = r_tag3;
    assign o_value = signed'(r_value);

endmodule
`default_nettype wire

@@ rtl/conv3x3_valid_bias_top.sv @@
// Top level of the streaming 3x3 valid-mode convolution with bias.
// Throughput: one pixel per cycle while no finished result waits; the line buffer
// chain advances once per accepted beat, and the three-stage multiply-add pipeline
// whenever no finished result waits.
// Reset clears position counters, window, pipeline valids and the registers
// (weights to 0, bias to 1); line buffer contents are not reset.
`default_nettype none
module conv3x3_valid_bias_top #(
    parameter int IMAGE_SIDE = cvb_pkg::IMAGE_SIDE_DEF
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_in_valid,
    output logic                                   o_in_ready,
    input  wire logic [cvb_pkg::PIX_W-1:0]         i_pixel,
    output logic                                   o_out_valid,
    input  wire logic                              i_out_ready,
    output logic signed [cvb_pkg::VALUE_W-1:0]     o_value,
    output logic                                   o_last,
    input  wire logic                              i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  wire logic [cvb_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  wire logic [cvb_pkg::VALUE_W-1:0]       i_cfg_data
);
    import cvb_pkg::*;

    localparam int              CW       = $clog2(IMAGE_SIDE);
    localparam logic [CW-1:0]   LAST_POS = CW'(IMAGE_SIDE - 1);
    localparam logic [CW-1:0]   FIRST_IN = CW'(2);

    t_wrows             r_wrow;
    logic [VALUE_W-1:0] r_bias;
    logic [CW-1:0]      r_col;
    logic [CW-1:0]      r_row;
    logic [CW-1:0]      n_col;
    logic [CW-1:0]      n_row;
    logic [1:0][KSIZE-1:0][PIX_W-1:0] r_win;
    logic [KSIZE-1:0][PIX_W-1:0]      w_cur;
    logic [LINE_W-1:0]  w_line [IMAGE_SIDE];
    logic [LINE_W-1:0]  w_new_entry;
    logic               w_en;
    logic               w_in_acc;
    t_win               w_win;
    t_tag               w_tag_in;
    t_tag               w_tag_out;

    // The whole pipeline moves unless a finished result is waiting.
    assign w_en        = !w_tag_out.valid || i_out_ready;
    assign o_in_ready  = w_en;
    assign w_in_acc    = i_in_valid && w_en;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wrow <= '0;
            r_bias <= BIAS_RESET;
        end else if (i_cfg_valid) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_WROW0: r_wrow[0] <= i_cfg_data[WROW_W-1:0];
                CFG_WROW1: r_wrow[1] <= i_cfg_data[WROW_W-1:0];
                CFG_WROW2: r_wrow[2] <= i_cfg_data[WROW_W-1:0];
                CFG_BIAS:  r_bias    <= i_cfg_data;
                default:   r_bias    <= r_bias;
            endcase
        end
    end

    // The oldest cell holds the entry for the current column: two rows up
    // in the high byte, one row up in the low byte.
    assign w_cur[0]    = w_line[IMAGE_SIDE-1][LINE_W-1:PIX_W];
    assign w_cur[1]    = w_line[IMAGE_SIDE-1][PIX_W-1:0];
    assign w_cur[2]    = i_pixel;
    assign w_new_entry = {w_cur[1], w_cur[2]};

    for (genvar g = 0; g < IMAGE_SIDE; g++) begin : g_line
        if (g == 0) begin : g_head
            cvb_line_cell u_cell (
                .i_clk  (i_clk),
                .i_en   (w_in_acc),
                .i_data (w_new_entry),
                .o_data (w_line[g])
            );
        end else begin : g_body
            cvb_line_cell u_cell (
                .i_clk  (i_clk),
                .i_en   (w_in_acc),
                .i_data (w_line[g-1]),
                .o_data (w_line[g])
            );
        end
    end

    always_comb begin
        for (int k = 0; k < KSIZE; k++) begin
            w_win[k][0] = r_win[0][k];
            w_win[k][1] = r_win[1][k];
            w_win[k][2] = w_cur[k];
        end
    end

    assign w_tag_in.valid = w_in_acc && (r_row >= FIRST_IN) && (r_col >= FIRST_IN);
    assign w_tag_in.last  = (r_row == LAST_POS) && (r_col == LAST_POS);

    always_comb begin
        n_col = r_col + 1'b1;
        n_row = r_row;
        if (r_col == LAST_POS) begin
            n_col = '0;
            n_row = (r_row == LAST_POS) ? '0 : r_row + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
            r_win <= '0;
        end else if (w_in_acc) begin
            r_col    <= n_col;
            r_row    <= n_row;
            r_win[0] <= r_win[1];
            r_win[1] <= w_cur;
        end
    end

    cvb_mac u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_tag   (w_tag_in),
        .i_win   (w_win),
        .i_wrow  (r_wrow),
        .i_bias  (r_bias),
        .o_tag   (w_tag_out),
        .o_value (o_value)
    );

    assign o_out_valid = w_tag_out.valid;
    assign o_last      = w_tag_out.last;

    a_col_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc && r_col != LAST_POS |=> r_col == $past(r_col) + 1'b1)
        else $error("column counter did not advance by one");

    a_row_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc && r_col != LAST_POS |=> $stable(r_row))
        else $error("row changed without a column wrap");

    a_image_wrap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc && r_col == LAST_POS && r_row == LAST_POS |=> r_col == '0 && r_row == '0)
        else $error("position counters did not wrap after the last pixel");

    a_idle_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_in_acc |=> $stable(r_col) && $stable(r_row))
        else $error("position moved without an accepted beat");

endmodule
`default_nettype wire

@@ test/tb_conv3x3_valid_bias_top.sv @@
// Self-checking testbench for the streaming 3x3 valid-mode convolution with bias.
module tb_conv3x3_valid_bias_top;
    import cvb_pkg::*;

    localparam int SIDE             = IMAGE_SIDE_DEF;
    localparam int DIR_ROWS         = 5;
    localparam int DIR_PIXELS       = DIR_ROWS * SIDE;
    localparam int RAND_PIXELS      = 1000;
    localparam int SETTLE_CYCLES    = 8;
    localparam int STALL_LIMIT      = 2000;

    typedef enum logic {FILL_CONST, FILL_RAMP} t_fill_kind;

    // One directed run: optional register set, pixel pattern, and the
    // window value when it is obvious from a uniform image.
    typedef struct packed {
        logic               do_write;
        logic [31:0]        wrow0;
        logic [31:0]        wrow1;
        logic [31:0]        wrow2;
        logic [31:0]        bias;
        t_fill_kind         fill;
        logic [PIX_W-1:0]   px;
        logic               typed;
        logic [31:0]        value;
    } t_img_case;

    typedef struct packed {
        logic signed [VALUE_W-1:0] value;
        logic                      last;
    } t_conv_out;

    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  i_in_valid  = 1'b0;
    logic [PIX_W-1:0]      i_pixel     = '0;
    logic                  i_out_ready = 1'b0;
    logic                  i_cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index = CFG_WROW0;
    logic [VALUE_W-1:0]    i_cfg_data  = '0;
    logic                  o_in_ready;
    logic                  o_out_valid;
    logic signed [VALUE_W-1:0] o_value;
    logic                  o_last;
    logic                  o_cfg_ready;

    conv3x3_valid_bias_top #(
        .IMAGE_SIDE (SIDE)
    ) u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_pixel     (i_pixel),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_value     (o_value),
        .o_last      (o_last),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    t_img_case dir_cases [5] = '{
        '{1'b0, 32'h0, 32'h0, 32'h0, 32'h1, FILL_CONST, 8'hFF, 1'b1, 32'd1},
        '{1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h7FFF_FFFF,
          FILL_CONST, 8'hFF, 1'b1, 32'h8008_EE08},
        '{1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h8000_0000,
          FILL_CONST, 8'h00, 1'b1, 32'h8000_0000},
        '{1'b1, 32'hA503_0201, 32'h5A06_0504, 32'hFF09_0807, 32'hFFFF_FFFF,
          FILL_RAMP, 8'h00, 1'b0, 32'h0},
        '{1'b1, 32'h0001_0101, 32'h0001_0101, 32'h0001_0101, 32'h0,
          FILL_CONST, 8'h80, 1'b1, 32'd1152}
    };

    t_cfg_idx reg_list [4] = '{CFG_WROW0, CFG_WROW1, CFG_WROW2, CFG_BIAS};

    // Predictor state.
    logic [LINE_W-1:0]     line_mem [SIDE];
    logic [2:0][PIX_W-1:0] col_old  = '0;
    logic [2:0][PIX_W-1:0] col_mid  = '0;
    logic [2:0][23:0]      kern     = '0;
    logic [31:0]           bias_reg = BIAS_RESET;
    int                    col_pos  = 0;
    int                    row_pos  = 0;

    t_conv_out  window_q [$];
    t_conv_out  pred_beat;
    t_conv_out  want_beat;
    logic       typed_en    = 1'b0;
    logic [31:0] typed_value = '0;
    int         case_px     = 0;
    int         fail_count  = 0;
    int         idle_cycles = 0;
    int         tx_calm     = 0;
    int         rx_calm     = 0;
    int         rx_hold     = 0;
    int         rx_roll;

    function automatic bit conv_predict(input logic [PIX_W-1:0] px, output t_conv_out beat);
        logic [2:0][PIX_W-1:0] cur;
        logic [PIX_W-1:0]      p;
        logic [31:0]           acc;
        bit                    fires;
        cur[0] = line_mem[col_pos][15:8];
        cur[1] = line_mem[col_pos][7:0];
        cur[2] = px;
        fires  = (row_pos >= 2) && (col_pos >= 2);
        acc    = bias_reg;
        for (int k = 0; k < KSIZE; k++) begin
            for (int l = 0; l < KSIZE; l++) begin
                p   = (l == 0) ? col_old[k] : (l == 1) ? col_mid[k] : cur[k];
                acc = acc + {24'd0, p} * {24'd0, kern[k][8*l +: 8]};
            end
        end
        beat.value = acc;
        beat.last  = (row_pos == SIDE - 1) && (col_pos == SIDE - 1);
        line_mem[col_pos] = {cur[1], cur[2]};
        col_old = col_mid;
        col_mid = cur;
        if (col_pos == SIDE - 1) begin
            col_pos = 0;
            row_pos = (row_pos == SIDE - 1) ? 0 : row_pos + 1;
        end else begin
            col_pos = col_pos + 1;
        end
        return fires;
    endfunction

    function automatic int pick_gap();
        int r;
        if (tx_calm > 0) begin
            tx_calm = tx_calm - 1;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 2) begin
            tx_calm = $urandom_range(60, 250);
            return 0;
        end
        if (r < 65) return 0;
        if (r < 94) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [31:0] pick_word();
        case ($urandom_range(0, 7))
            0: return 32'h0;
            1: return 32'hFFFF_FFFF;
            2: return 32'h7FFF_FFFF;
            3: return 32'h8000_0000;
            default: return $urandom();
        endcase
    endfunction

    function automatic logic [PIX_W-1:0] pick_pixel();
        case ($urandom_range(0, 9))
            0: return 8'h00;
            1: return 8'hFF;
            default: return 8'($urandom());
        endcase
    endfunction

    task automatic push_pixel(input logic [PIX_W-1:0] px);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_pixel    <= px;
        do @(posedge i_clk); while (!o_in_ready);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [31:0] data);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            i_cfg_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
    endtask

    // Border pixels leave the pipeline busy without a result, so pad after
    // the last expected beat before touching the registers.
    task automatic settle();
        do @(posedge i_clk); while (window_q.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Receiver: mostly ready, short and occasional long stalls, calm stretches.
    always @(posedge i_clk) begin
        if (rx_hold > 0) begin
            i_out_ready <= 1'b0;
            rx_hold = rx_hold - 1;
        end else begin
            i_out_ready <= 1'b1;
            if (rx_calm > 0) begin
                rx_calm = rx_calm - 1;
            end else begin
                rx_roll = $urandom_range(0, 99);
                if (rx_roll < 2)
                    rx_calm = $urandom_range(60, 250);
                else if (rx_roll < 20)
                    rx_hold = $urandom_range(1, 3);
                else if (rx_roll < 24)
                    rx_hold = $urandom_range(8, 40);
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready) begin
                case (t_cfg_idx'(i_cfg_index))
                    CFG_WROW0: kern[0]  = i_cfg_data[WROW_W-1:0];
                    CFG_WROW1: kern[1]  = i_cfg_data[WROW_W-1:0];
                    CFG_WROW2: kern[2]  = i_cfg_data[WROW_W-1:0];
                    CFG_BIAS:  bias_reg = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_in_valid && o_in_ready) begin
                if (conv_predict(i_pixel, pred_beat)) begin
                    // Only windows past the first two rows of a run are uniform.
                    if (typed_en && case_px >= 2 * SIDE)
                        pred_beat.value = typed_value;
                    window_q.push_back(pred_beat);
                end
                case_px = case_px + 1;
            end
            if (o_out_valid && i_out_ready) begin
                if (window_q.size() == 0) begin
                    $error("unexpected beat: value %0d last %0b", o_value, o_last);
                    fail_count++;
                end else begin
                    want_beat = window_q.pop_front();
                    if (o_value !== want_beat.value) begin
                        $error("value: expected %0d (%h), got %0d (%h)",
                               want_beat.value, want_beat.value, o_value, o_value);
                        fail_count++;
                    end
                    if (o_last !== want_beat.last) begin
                        $error("last: expected %0b, got %0b", want_beat.last, o_last);
                        fail_count++;
                    end
                end
            end
        end
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) ||
            (i_cfg_valid && o_cfg_ready))
            idle_cycles = 0;
        else
            idle_cycles = idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("conv3x3_valid_bias_top regression: fail");
            $finish;
        end
    end

    initial begin
        t_img_case img;
        int        sent;
        int        run_len;
        bit        first_pass;
        foreach (line_mem[n]) line_mem[n] = '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Runs of whole rows, so each starts at column 0 of a fresh row.
        foreach (dir_cases[n]) begin
            img = dir_cases[n];
            if (img.do_write) begin
                write_reg(CFG_WROW0, img.wrow0);
                write_reg(CFG_WROW1, img.wrow1);
                write_reg(CFG_WROW2, img.wrow2);
                write_reg(CFG_BIAS, img.bias);
                i_cfg_valid <= 1'b0;
            end
            typed_value = img.value;
            typed_en    = img.typed;
            case_px     = 0;
            for (int i = 0; i < DIR_PIXELS; i++)
                push_pixel((img.fill == FILL_CONST) ? img.px : 8'(i * 7));
            i_in_valid <= 1'b0;
            settle();
            typed_en = 1'b0;
        end

        // Random runs of arbitrary length, so settings change mid-image.
        sent       = 0;
        first_pass = 1'b1;
        while (sent < RAND_PIXELS) begin
            foreach (reg_list[r]) begin
                if (first_pass || $urandom_range(0, 9) < 6)
                    write_reg(reg_list[r], pick_word());
            end
            i_cfg_valid <= 1'b0;
            first_pass = 1'b0;
            run_len    = $urandom_range(40, 600);
            if (run_len > RAND_PIXELS - sent)
                run_len = RAND_PIXELS - sent;
            for (int i = 0; i < run_len; i++)
                push_pixel(pick_pixel());
            sent = sent + run_len;
            i_in_valid <= 1'b0;
            settle();
        end

        if (fail_count == 0)
            $display("conv3x3_valid_bias_top regression: pass");
        else
            $display("conv3x3_valid_bias_top regression: fail");
        $finish;
    end

endmodule
